/* hw/rtl/tks_pkg.sv */
// Package for the topic key store: sizes, operation codes and the structs
// passed between the pipeline registers and the table. No dependencies.
package tks_pkg;

    localparam int ENTRIES   = 16;
    localparam int HASH_BITS = 64;
    localparam int KEY_BITS  = 64;

    // Slot index and used-count widths follow from the table depth.
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Fixed widths of the item fields.
    localparam int FUNC_W  = 3;
    localparam int WORD_W  = 64;
    localparam int SLOT_W  = 4;
    localparam int ECNT_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR_ALL    = 3'd0,
        FN_LOOKUP       = 3'd1,
        FN_READ_KEY     = 3'd2,
        FN_SET_KEY      = 3'd3,
        FN_REMOVE       = 3'd4,
        FN_CLEAR_TOPICS = 3'd5,
        FN_SET_ID       = 3'd6
    } t_func;

    typedef enum logic {
        ST_OK   = 1'b0,
        ST_FAIL = 1'b1
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] topic_digest;
        logic [WORD_W-1:0] key_in;
        logic [SLOT_W-1:0] slot_index;
        logic              hash_present;
        logic              key_present;
    } t_cmd;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] found_index;
        logic [WORD_W-1:0] key_out;
        logic [ECNT_W-1:0] entry_count;
    } t_rsp;

    // Outcome of the parallel hash compare and the two priority encoders.
    typedef struct packed {
        logic [ENTRIES-1:0] match;
        logic               hit;
        logic [IDX_W-1:0]   hit_idx;
        logic               free_ok;
        logic [IDX_W-1:0]   free_idx;
    } t_lookup;

endpackage

/* hw/rtl/tks_in_if.sv */
// Command channel of the topic key store: valid/ready handshake and the
// fields of one command item. Depends on tks_pkg for the field widths.
interface tks_in_if;
    logic                      valid;
    logic                      ready;
    logic [tks_pkg::FUNC_W-1:0] func;
    logic [tks_pkg::WORD_W-1:0] topic_digest;
    logic [tks_pkg::WORD_W-1:0] key_in;
    logic [tks_pkg::SLOT_W-1:0] slot_index;
    logic                      hash_present;
    logic                      key_present;

    modport source (
        output valid, func, topic_digest, key_in, slot_index, hash_present, key_present,
        input  ready
    );
    modport sink (
        input  valid, func, topic_digest, key_in, slot_index, hash_present, key_present,
        output ready
    );
endinterface

/* hw/rtl/tks_out_if.sv */
// Response channel of the topic key store: valid/ready handshake and the
// fields of one response item. Depends on tks_pkg for the field widths.
interface tks_out_if;
    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [tks_pkg::SLOT_W-1:0] found_index;
    logic [tks_pkg::WORD_W-1:0] key_out;
    logic [tks_pkg::ECNT_W-1:0] entry_count;

    modport source (
        output valid, status, found_index, key_out, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, found_index, key_out, entry_count,
        output ready
    );
endinterface

/* hw/rtl/tks_lookup.sv */
// Parallel hash compare over all slots with priority encoders for the
// lowest matching used slot and the lowest free slot. Depends on tks_pkg.
module tks_lookup (
    input  logic [tks_pkg::ENTRIES-1:0]   i_used,
    input  logic [tks_pkg::HASH_BITS-1:0] i_hashes [tks_pkg::ENTRIES],
    input  logic [tks_pkg::HASH_BITS-1:0] i_hash,
    output tks_pkg::t_lookup              o_lookup
);

    always_comb begin
        o_lookup = '0;
        for (int i = 0; i < tks_pkg::ENTRIES; i++) begin
            o_lookup.match[i] = i_used[i] && (i_hashes[i] == i_hash);
        end
        // Scan downwards so that the lowest slot wins.
        for (int i = tks_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (o_lookup.match[i]) begin
                o_lookup.hit     = 1'b1;
                o_lookup.hit_idx = tks_pkg::IDX_W'(i);
            end
            if (!i_used[i]) begin
                o_lookup.free_ok  = 1'b1;
                o_lookup.free_idx = tks_pkg::IDX_W'(i);
            end
        end
    end

endmodule

/* hw/rtl/tks_table.sv */
// Slot storage (used flags, hashes, keys, used count) and the combinational
// operation logic that updates it and forms a response. Uses tks_pkg and
// tks_lookup.
module tks_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  tks_pkg::t_cmd i_cmd,
    output tks_pkg::t_rsp o_rsp
);

    logic [tks_pkg::ENTRIES-1:0]   r_used;
    logic [tks_pkg::ENTRIES-1:0]   n_used;
    logic [tks_pkg::CNT_W-1:0]     r_count;
    logic [tks_pkg::CNT_W-1:0]     n_count;
    logic [tks_pkg::HASH_BITS-1:0] r_hash [tks_pkg::ENTRIES];
    logic [tks_pkg::KEY_BITS-1:0]  r_key  [tks_pkg::ENTRIES];

    logic [tks_pkg::HASH_BITS-1:0] hash;
    logic [tks_pkg::KEY_BITS-1:0]  key;
    logic [tks_pkg::IDX_W-1:0]     rd_idx;
    logic [tks_pkg::IDX_W-1:0]     wr_idx;
    logic                          hash_we;
    logic                          key_we;
    logic                          rd_in_range;
    tks_pkg::t_lookup              lk;

    assign hash        = i_cmd.topic_digest[tks_pkg::HASH_BITS-1:0];
    assign key         = i_cmd.key_in[tks_pkg::KEY_BITS-1:0];
    assign rd_idx      = tks_pkg::IDX_W'(i_cmd.slot_index);
    assign rd_in_range = int'(i_cmd.slot_index) < tks_pkg::ENTRIES;

    tks_lookup u_lookup (
        .i_used   (r_used),
        .i_hashes (r_hash),
        .i_hash   (hash),
        .o_lookup (lk)
    );

    always_comb begin
        n_used  = r_used;
        n_count = r_count;
        wr_idx  = '0;
        hash_we = 1'b0;
        key_we  = 1'b0;
        o_rsp   = '0;

        case (i_cmd.func)
            tks_pkg::FN_CLEAR_ALL: begin
                n_used  = '0;
                n_count = '0;
            end
            tks_pkg::FN_LOOKUP: begin
                if (lk.hit) begin
                    o_rsp.found_index = tks_pkg::SLOT_W'(lk.hit_idx);
                end else begin
                    o_rsp.status = tks_pkg::ST_FAIL;
                end
            end
            tks_pkg::FN_READ_KEY: begin
                if (rd_in_range && r_used[rd_idx]) begin
                    o_rsp.key_out = tks_pkg::WORD_W'(r_key[rd_idx]);
                end else begin
                    o_rsp.status = tks_pkg::ST_FAIL;
                end
            end
            tks_pkg::FN_SET_KEY: begin
                if (lk.hit) begin
                    wr_idx = lk.hit_idx;
                    key_we = 1'b1;
                end else if (lk.free_ok) begin
                    wr_idx           = lk.free_idx;
                    hash_we          = 1'b1;
                    key_we           = 1'b1;
                    n_used[lk.free_idx] = 1'b1;
                    n_count          = r_count + 1'b1;
                end else begin
                    o_rsp.status = tks_pkg::ST_FAIL;
                end
            end
            tks_pkg::FN_REMOVE: begin
                n_used  = r_used & ~lk.match;
                n_count = r_count - tks_pkg::CNT_W'($countones(lk.match));
                if (!lk.hit) begin
                    o_rsp.status = tks_pkg::ST_FAIL;
                end
            end
            tks_pkg::FN_CLEAR_TOPICS: begin
                n_used    = '0;
                n_used[0] = r_used[0];
                n_count   = tks_pkg::CNT_W'(r_used[0]);
            end
            tks_pkg::FN_SET_ID: begin
                hash_we = i_cmd.hash_present;
                key_we  = i_cmd.key_present;
                if (i_cmd.hash_present && i_cmd.key_present && !r_used[0]) begin
                    n_used[0] = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            default: begin
                o_rsp.status = tks_pkg::ST_FAIL;
            end
        endcase

        o_rsp.entry_count = tks_pkg::ECNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_used  <= n_used;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && hash_we) begin
            r_hash[wr_idx] <= hash;
        end
        if (i_fire && key_we) begin
            r_key[wr_idx] <= key;
        end
    end

    // The running count must always agree with the used flags.
    a_count_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == tks_pkg::CNT_W'($countones(r_used)))
        else $error("used count differs from number of used slots");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cmd.func == tks_pkg::FN_CLEAR_ALL) |=> (r_used == '0))
        else $error("slots still in use after clear all");

    a_remove_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cmd.func == tks_pkg::FN_REMOVE)
            |=> ((r_used & $past(lk.match)) == '0))
        else $error("matching slot survived remove");

    a_set_id_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cmd.func == tks_pkg::FN_SET_ID && i_cmd.hash_present
            && i_cmd.key_present) |=> r_used[0])
        else $error("identity slot not marked used after full set id");

endmodule

/* hw/rtl/topic_key_store.sv */
// Top level of the topic key store: command register, slot table and
// response register. Uses tks_pkg, tks_in_if, tks_out_if and tks_table.
//
//  Channel   Direction  Handshake          Carries
//  i_cmd     in         valid/ready        func, topic_digest, key_in, slot_index,
//                                          hash_present, key_present
//  o_rsp     out        valid/ready        status, found_index, key_out, entry_count
//
// Each command item is captured in the command register; it is then carried out against
// the slot table and its response item is loaded into the response register once that
// register can take it, after which the response is held valid until it is taken.
// One item is accepted every cycle while the response is not stalled; the rate is set by
// the combinational compare of all stored hashes and the priority encoders behind it.
// A stalled response holds the response register, and the command register
// behind it takes at most one more item before the input ready drops.
// Synchronous active-low reset empties both registers and marks every slot free;
// stored hashes and keys are not cleared, since a free slot is never read.
module topic_key_store (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tks_in_if.sink    i_cmd,
    tks_out_if.source o_rsp
);

    logic          r_cmd_valid;
    tks_pkg::t_cmd r_cmd;
    logic          r_rsp_valid;
    tks_pkg::t_rsp r_rsp;
    tks_pkg::t_rsp rsp;
    logic          rsp_take;
    logic          fire;

    // The response register can take a new item when empty or being drained.
    assign rsp_take    = !r_rsp_valid || o_rsp.ready;
    assign fire        = r_cmd_valid && rsp_take;
    assign i_cmd.ready = !r_cmd_valid || rsp_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_cmd_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_cmd.func         <= i_cmd.func;
            r_cmd.topic_digest <= i_cmd.topic_digest;
            r_cmd.key_in       <= i_cmd.key_in;
            r_cmd.slot_index   <= i_cmd.slot_index;
            r_cmd.hash_present <= i_cmd.hash_present;
            r_cmd.key_present  <= i_cmd.key_present;
        end
    end

    tks_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cmd   (r_cmd),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (rsp_take) begin
            r_rsp_valid <= r_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rsp <= rsp;
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_rsp.status;
    assign o_rsp.found_index = r_rsp.found_index;
    assign o_rsp.key_out     = r_rsp.key_out;
    assign o_rsp.entry_count = r_rsp.entry_count;

endmodule

/* verif/tks_checker.sv */
`timescale 1ns / 100ps
// Checker for the topic key store: watches the command and response channels,
// keeps its own copy of the slot table and compares every response item.
// Depends on tks_pkg, tks_in_if and tks_out_if.
module tks_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tks_in_if    i_cmd,
    tks_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    logic [tks_pkg::ENTRIES-1:0]   slot_used;
    logic [tks_pkg::HASH_BITS-1:0] slot_hash [tks_pkg::ENTRIES];
    logic [tks_pkg::KEY_BITS-1:0]  slot_key  [tks_pkg::ENTRIES];

    tks_pkg::t_rsp expected_rsps [$];
    tks_pkg::t_rsp want;
    tks_pkg::t_rsp got;
    int   fail_total    = 0;
    int   pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    // Carries out one command on the shadow table and returns its response.
    function automatic tks_pkg::t_rsp apply_command(input tks_pkg::t_cmd c);
        tks_pkg::t_rsp                 r;
        logic [tks_pkg::HASH_BITS-1:0] h;
        logic [tks_pkg::KEY_BITS-1:0]  k;
        int                            hit;
        int                            free;
        int                            n;
        int                            i;
        r    = '0;
        h    = c.topic_digest[tks_pkg::HASH_BITS-1:0];
        k    = c.key_in[tks_pkg::KEY_BITS-1:0];
        hit  = -1;
        free = -1;
        // Walking downwards leaves the lowest matching and lowest free slot.
        for (i = tks_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_hash[i] == h) hit = i;
            if (!slot_used[i]) free = i;
        end
        case (c.func)
            tks_pkg::FN_CLEAR_ALL: begin
                slot_used = '0;
            end
            tks_pkg::FN_LOOKUP: begin
                if (hit < 0) r.status = tks_pkg::ST_FAIL;
                else r.found_index = tks_pkg::SLOT_W'(hit);
            end
            tks_pkg::FN_READ_KEY: begin
                if (int'(c.slot_index) < tks_pkg::ENTRIES && slot_used[c.slot_index])
                    r.key_out = tks_pkg::WORD_W'(slot_key[c.slot_index]);
                else
                    r.status = tks_pkg::ST_FAIL;
            end
            tks_pkg::FN_SET_KEY: begin
                if (hit >= 0) begin
                    slot_key[hit] = k;
                end else if (free >= 0) begin
                    slot_used[free] = 1'b1;
                    slot_hash[free] = h;
                    slot_key[free]  = k;
                end else begin
                    r.status = tks_pkg::ST_FAIL;
                end
            end
            tks_pkg::FN_REMOVE: begin
                r.status = tks_pkg::ST_FAIL;
                for (i = 0; i < tks_pkg::ENTRIES; i++) begin
                    if (slot_used[i] && slot_hash[i] == h) begin
                        slot_used[i] = 1'b0;
                        r.status     = tks_pkg::ST_OK;
                    end
                end
            end
            tks_pkg::FN_CLEAR_TOPICS: begin
                slot_used[tks_pkg::ENTRIES-1:1] = '0;
            end
            tks_pkg::FN_SET_ID: begin
                if (c.hash_present) slot_hash[0] = h;
                if (c.key_present) slot_key[0] = k;
                if (c.hash_present && c.key_present) slot_used[0] = 1'b1;
            end
            default: begin
                r.status = tks_pkg::ST_FAIL;
            end
        endcase
        n = 0;
        for (i = 0; i < tks_pkg::ENTRIES; i++) if (slot_used[i]) n++;
        r.entry_count = tks_pkg::ECNT_W'(n);
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        fail_total++;
        if (fail_total <= 10)
            $display("tks_checker: %s mismatch, expected %0h, got %0h", field, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slot_used = '0;
            expected_rsps.delete();
        end else begin
            // Responses pass the command and response registers after their commands
            // are taken, so the response side is handled first.
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{status: i_rsp.status, found_index: i_rsp.found_index,
                        key_out: i_rsp.key_out, entry_count: i_rsp.entry_count};
                if (expected_rsps.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("tks_checker: response item with none outstanding");
                end else begin
                    want = expected_rsps.pop_front();
                    if (got.status !== want.status)
                        note_mismatch("status", 64'(want.status), 64'(got.status));
                    if (got.found_index !== want.found_index)
                        note_mismatch("found_index", 64'(want.found_index),
                                      64'(got.found_index));
                    if (got.key_out !== want.key_out)
                        note_mismatch("key_out", want.key_out, got.key_out);
                    if (got.entry_count !== want.entry_count)
                        note_mismatch("entry_count", 64'(want.entry_count),
                                      64'(got.entry_count));
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                expected_rsps.push_back(apply_command('{
                    func: i_cmd.func, topic_digest: i_cmd.topic_digest,
                    key_in: i_cmd.key_in, slot_index: i_cmd.slot_index,
                    hash_present: i_cmd.hash_present,
                    key_present: i_cmd.key_present}));
            end
        end
        pending_total = expected_rsps.size();
    end

endmodule

/* verif/tb_topic_key_store.sv */
`timescale 1ns / 100ps
// Testbench top for the topic key store: clock, reset, command stimulus and
// response back-pressure, with tks_checker beside the block giving the verdict.
// Depends on tks_pkg, tks_in_if, tks_out_if, tks_checker and topic_key_store.
module tb_topic_key_store;

    // The one func code that the block does not define; it must answer with a
    // failure status and leave the table alone.
    localparam logic [tks_pkg::FUNC_W-1:0] FN_UNDEFINED = 3'd7;

    localparam int RANDOM_ITEMS = 1920;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int POOL_SIZE    = 24;
    // Item numbers, within the random part, of the pressure phases.
    localparam int STEADY_FIRST = 600;
    localparam int STEADY_LAST  = 900;
    localparam int DRAIN_ITEM   = 1300;
    localparam int HOLD_CYCLES  = 40;
    localparam int CALM_CYCLES  = 300;

    logic i_clk;
    logic i_rst_n;

    tks_in_if  cmd_if ();
    tks_out_if rsp_if ();

    int   fail_count;
    int   pending_rsps;
    int   cycle_count;
    logic steady_sender;

    logic [tks_pkg::WORD_W-1:0] hash_pool [POOL_SIZE];

    topic_key_store DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    tks_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_rsps)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[topic_key_store] ERROR");
        $finish;
    end

    // Response side. Ready is normally dropped with a chance of about 15 in a
    // hundred. When the sender starts its steady stretch the receiver refuses
    // every response item for a hold stretch, so the two internal registers
    // fill and the command channel must stall; afterwards it takes every
    // item for a long calm stretch.
    initial begin
        int   calm_left;
        logic hold_done;
        calm_left    = 0;
        hold_done    = 1'b0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (steady_sender && !hold_done) begin
                hold_done = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                calm_left = CALM_CYCLES;
            end else if (calm_left > 0) begin
                rsp_if.ready <= 1'b1;
                calm_left--;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= 15);
            end
        end
    end

    function automatic tks_pkg::t_cmd make_cmd(input logic [tks_pkg::FUNC_W-1:0] func,
                                               input logic [tks_pkg::WORD_W-1:0] hash,
                                               input logic [tks_pkg::WORD_W-1:0] key,
                                               input logic [tks_pkg::SLOT_W-1:0] slot,
                                               input logic hp, input logic kp);
        tks_pkg::t_cmd c;
        c.func         = func;
        c.topic_digest = hash;
        c.key_in       = key;
        c.slot_index   = slot;
        c.hash_present = hp;
        c.key_present  = kp;
        return c;
    endfunction

    // Random command. Hashes mostly come from a small pool so that lookups
    // hit, keys get updated and the table fills up; set-key outweighs the
    // removals and clears so that the full-table case is reached often.
    function automatic tks_pkg::t_cmd random_cmd();
        logic [tks_pkg::FUNC_W-1:0] func;
        logic [tks_pkg::WORD_W-1:0] hash;
        logic [tks_pkg::WORD_W-1:0] key;
        int                         pick;
        pick = $urandom_range(999);
        if (pick < 380)      func = tks_pkg::FN_SET_KEY;
        else if (pick < 580) func = tks_pkg::FN_LOOKUP;
        else if (pick < 730) func = tks_pkg::FN_READ_KEY;
        else if (pick < 860) func = tks_pkg::FN_REMOVE;
        else if (pick < 975) func = tks_pkg::FN_SET_ID;
        else if (pick < 990) func = tks_pkg::FN_CLEAR_TOPICS;
        else                 func = tks_pkg::FN_CLEAR_ALL;
        if ($urandom_range(9) == 0) hash = {$urandom, $urandom};
        else hash = hash_pool[$urandom_range(POOL_SIZE - 1)];
        case ($urandom_range(9))
            0:       key = '0;
            1:       key = '1;
            default: key = {$urandom, $urandom};
        endcase
        return make_cmd(func, hash, key, tks_pkg::SLOT_W'($urandom_range(15)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    // Offers one command item, after an idle gap now and then, and returns at
    // the falling edge after it was taken. Valid stays high between items
    // that follow each other without a gap.
    task automatic send_item(input tks_pkg::t_cmd c);
        if (!steady_sender && $urandom_range(99) < 15) begin
            cmd_if.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < 15);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.func         <= c.func;
        cmd_if.topic_digest <= c.topic_digest;
        cmd_if.key_in       <= c.key_in;
        cmd_if.slot_index   <= c.slot_index;
        cmd_if.hash_present <= c.hash_present;
        cmd_if.key_present  <= c.key_present;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int i;
        steady_sender       = 1'b0;
        i_rst_n             = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.func         = tks_pkg::FN_CLEAR_ALL;
        cmd_if.topic_digest = '0;
        cmd_if.key_in       = '0;
        cmd_if.slot_index   = '0;
        cmd_if.hash_present = 1'b0;
        cmd_if.key_present  = 1'b0;

        hash_pool[0] = '0;
        hash_pool[1] = '1;
        for (i = 2; i < POOL_SIZE; i++) hash_pool[i] = {$urandom, $urandom};

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. On the empty table a lookup and a remove both miss.
        send_item(make_cmd(tks_pkg::FN_LOOKUP, '1, '0, '0, 1'b0, 1'b0));
        send_item(make_cmd(tks_pkg::FN_REMOVE, '0, '0, '0, 1'b0, 1'b0));
        // Identity entry written one part at a time stays unused, so reading
        // it fails; with both parts it becomes used.
        send_item(make_cmd(tks_pkg::FN_SET_ID, '1, '0, '0, 1'b1, 1'b0));
        send_item(make_cmd(tks_pkg::FN_SET_ID, '0, '1, '0, 1'b0, 1'b1));
        send_item(make_cmd(tks_pkg::FN_READ_KEY, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_cmd(tks_pkg::FN_SET_ID, '1, '0, '0, 1'b1, 1'b1));
        // Set-key matching the identity hash updates slot 0 in place.
        send_item(make_cmd(tks_pkg::FN_SET_KEY, '1, '1, '0, 1'b0, 1'b0));
        send_item(make_cmd(tks_pkg::FN_READ_KEY, '0, '0, '0, 1'b0, 1'b0));
        // Fill the other fifteen slots, then one more set-key finds it full.
        for (i = 0; i < tks_pkg::ENTRIES - 1; i++)
            send_item(make_cmd(tks_pkg::FN_SET_KEY, tks_pkg::WORD_W'(i),
                               ~tks_pkg::WORD_W'(i), '0, 1'b0, 1'b0));
        send_item(make_cmd(tks_pkg::FN_SET_KEY, {$urandom, $urandom}, '1, '0, 1'b0, 1'b0));
        send_item(make_cmd(tks_pkg::FN_LOOKUP, tks_pkg::WORD_W'(tks_pkg::ENTRIES - 2),
                           '0, '0, 1'b0, 1'b0));
        send_item(make_cmd(tks_pkg::FN_READ_KEY, '0, '0, '1, 1'b0, 1'b0));
        send_item(make_cmd(tks_pkg::FN_REMOVE, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_cmd(tks_pkg::FN_CLEAR_TOPICS, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_cmd(FN_UNDEFINED, '1, '1, '1, 1'b1, 1'b1));
        send_item(make_cmd(tks_pkg::FN_CLEAR_ALL, '0, '0, '0, 1'b0, 1'b0));

        // Random part, with the two pressure phases placed inside it.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            steady_sender = (i >= STEADY_FIRST && i < STEADY_LAST);
            if (i == DRAIN_ITEM) begin
                // Stop offering until every outstanding response has come.
                cmd_if.valid <= 1'b0;
                do @(negedge i_clk); while (pending_rsps != 0);
            end
            send_item(random_cmd());
        end

        // Drain: wait for the last responses, then a few cycles for strays.
        cmd_if.valid <= 1'b0;
        while (pending_rsps != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending_rsps == 0)
            $display("[topic_key_store] OK");
        else
            $display("[topic_key_store] ERROR");
        $finish;
    end

endmodule
